### design/ocwt_pkg.sv
// Package with the constants, types and state codes of the watermark table.
`default_nettype none
package ocwt_pkg;
   localparam int Capacity = 64;
   localparam int IdxWidth = $clog2(Capacity);
   localparam int CntWidth = $clog2(Capacity + 1);
   // Entry layout: committed, source, conn, op, time.
   localparam int EntryWidth = 1 + 12 + 32 + 32 + 64;

   localparam logic [1:0] ModeQueue = 2'd0;
   localparam logic [1:0] ModeCommit = 2'd1;
   localparam logic [1:0] ModeGraduate = 2'd2;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusDup = 2'd1;
   localparam logic [1:0] StatusFull = 2'd2;
   localparam logic [1:0] StatusNotFound = 2'd3;

   localparam logic [1:0] FoundAbsent = 2'd0;
   localparam logic [1:0] FoundPending = 2'd1;
   localparam logic [1:0] FoundCommitted = 2'd2;

   typedef struct packed {
      logic        committed;
      logic [11:0] source;
      logic [31:0] conn;
      logic [31:0] op;
      logic [63:0] stamp;
   } entry_type;

   typedef enum logic [3:0] {
      StIdle,
      StScanRead,
      StScanCheck,
      StDecide,
      StMarkWrite,
      StWalkRead,
      StWalkCheck,
      StMoveRead,
      StMoveWrite,
      StInsert,
      StRespond
   } state_type;
endpackage
`default_nettype wire

### design/ocwt_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none
module ocwt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

### design/ordered_commit_watermark_table_unit.sv
// Top level of the ordered commit watermark table.
`default_nettype none
// One item at a time: busy is high from acceptance through the result strobe. For the
// queue, commit and graduate modes the lookup scans the table through the single RAM port
// one entry at a time (read, then check) and stops at the matching entry; another mode
// goes straight to the strobe. A commit that found its entry then marks it committed. With
// a stamp it walks the source's entries, with a read and a check for each. A queue that is
// neither a duplicate nor full moves each later entry up, and a graduate pulls each later
// entry down, with a read and a write per moved entry. Such a queue then writes the new
// entry. The result strobe comes last. The next item can be taken in the cycle after the
// strobe at the earliest. The receiver cannot stall: rsp_valid is a one-cycle strobe.
module ordered_commit_watermark_table_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic [31:0]        req_conn_id,
   input  wire logic [31:0]        req_op_id,
   input  wire logic               req_has_stamp,
   input  wire logic [11:0]        req_source_id,
   input  wire logic [63:0]        req_stamp_time,
   output      logic               rsp_valid,
   output      logic [1:0]         rsp_status,
   output      logic [1:0]         rsp_found_state,
   output      logic signed [12:0] rsp_source_out,
   output      logic               rsp_max_valid,
   output      logic [63:0]        rsp_max_time
);
   localparam int IW = ocwt_pkg::IdxWidth;
   localparam int CW = ocwt_pkg::CntWidth;

   ocwt_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] self_ff, self_in;
   logic          pos_set_ff, pos_set_in;
   logic          self_set_ff, self_set_in;
   logic          dup_ff, dup_in;
   logic [1:0]    mode_ff, mode_in;
   logic [31:0]   conn_ff, conn_in;
   logic [31:0]   op_ff, op_in;
   logic          has_ff, has_in;
   logic [11:0]   src_ff, src_in;
   logic [63:0]   time_ff, time_in;
   logic [1:0]    status_ff, status_in;
   logic [1:0]    fstate_ff, fstate_in;
   logic          mvalid_ff, mvalid_in;
   logic [63:0]   mtime_ff, mtime_in;

   logic                  ram_we;
   logic [IW-1:0]         ram_addr;
   ocwt_pkg::entry_type   ram_wdata, ram_rdata;

   ocwt_ram #(.Width(ocwt_pkg::EntryWidth), .Depth(ocwt_pkg::Capacity)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   logic match_op;
   assign match_op = (ram_rdata.conn == conn_ff) && (ram_rdata.op == op_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ocwt_pkg::StIdle;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      self_ff <= self_in;
      pos_set_ff <= pos_set_in;
      self_set_ff <= self_set_in;
      dup_ff <= dup_in;
      mode_ff <= mode_in;
      conn_ff <= conn_in;
      op_ff <= op_in;
      has_ff <= has_in;
      src_ff <= src_in;
      time_ff <= time_in;
      status_ff <= status_in;
      fstate_ff <= fstate_in;
      mvalid_ff <= mvalid_in;
      mtime_ff <= mtime_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ocwt_pkg::StIdle: begin
            if (start) begin
               if (req_mode == ocwt_pkg::ModeQueue || req_mode == ocwt_pkg::ModeCommit ||
                   req_mode == ocwt_pkg::ModeGraduate) begin
                  state_in = ocwt_pkg::StScanRead;
               end else begin
                  state_in = ocwt_pkg::StRespond;
               end
            end
         end
         ocwt_pkg::StScanRead: begin
            state_in = (idx_ff < count_ff) ? ocwt_pkg::StScanCheck : ocwt_pkg::StDecide;
         end
         ocwt_pkg::StScanCheck: begin
            if (match_op) state_in = ocwt_pkg::StDecide;
            else state_in = ocwt_pkg::StScanRead;
         end
         ocwt_pkg::StDecide: begin
            case (mode_ff)
               ocwt_pkg::ModeQueue: begin
                  if (dup_ff || count_ff == CW'(ocwt_pkg::Capacity))
                     state_in = ocwt_pkg::StRespond;
                  else if (count_ff > pos_ff) state_in = ocwt_pkg::StMoveRead;
                  else state_in = ocwt_pkg::StInsert;
               end
               ocwt_pkg::ModeCommit: begin
                  if (self_set_ff) state_in = ocwt_pkg::StMarkWrite;
                  else if (has_ff) state_in = ocwt_pkg::StWalkRead;
                  else state_in = ocwt_pkg::StRespond;
               end
               default: begin
                  if (self_set_ff && self_ff + 1'b1 < count_ff)
                     state_in = ocwt_pkg::StMoveRead;
                  else state_in = ocwt_pkg::StRespond;
               end
            endcase
         end
         ocwt_pkg::StMarkWrite: begin
            state_in = has_ff ? ocwt_pkg::StWalkRead : ocwt_pkg::StRespond;
         end
         ocwt_pkg::StWalkRead: begin
            state_in = (idx_ff < count_ff) ? ocwt_pkg::StWalkCheck : ocwt_pkg::StRespond;
         end
         ocwt_pkg::StWalkCheck: begin
            if (ram_rdata.source == src_ff &&
                (!ram_rdata.committed || (self_set_ff && idx_ff == self_ff)))
               state_in = ocwt_pkg::StRespond;
            else state_in = ocwt_pkg::StWalkRead;
         end
         ocwt_pkg::StMoveRead: begin
            state_in = ocwt_pkg::StMoveWrite;
         end
         ocwt_pkg::StMoveWrite: begin
            if (mode_ff == ocwt_pkg::ModeQueue) begin
               state_in = (idx_ff - 1'b1 > pos_ff) ? ocwt_pkg::StMoveRead
                                                   : ocwt_pkg::StInsert;
            end else begin
               state_in = (idx_ff + 1'b1 < count_ff) ? ocwt_pkg::StMoveRead
                                                     : ocwt_pkg::StRespond;
            end
         end
         ocwt_pkg::StInsert: begin
            state_in = ocwt_pkg::StRespond;
         end
         ocwt_pkg::StRespond: begin
            state_in = ocwt_pkg::StIdle;
         end
         default: begin
            state_in = ocwt_pkg::StIdle;
         end
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      count_in = count_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      self_in = self_ff;
      pos_set_in = pos_set_ff;
      self_set_in = self_set_ff;
      dup_in = dup_ff;
      mode_in = mode_ff;
      conn_in = conn_ff;
      op_in = op_ff;
      has_in = has_ff;
      src_in = src_ff;
      time_in = time_ff;
      status_in = status_ff;
      fstate_in = fstate_ff;
      mvalid_in = mvalid_ff;
      mtime_in = mtime_ff;
      ram_we = 1'b0;
      ram_addr = idx_ff[IW-1:0];
      ram_wdata = ram_rdata;
      case (state_ff)
         ocwt_pkg::StIdle: begin
            mode_in = req_mode;
            conn_in = req_conn_id;
            op_in = req_op_id;
            has_in = req_has_stamp;
            src_in = req_source_id;
            time_in = req_stamp_time;
            idx_in = '0;
            pos_in = count_ff;
            pos_set_in = 1'b0;
            self_set_in = 1'b0;
            self_in = '0;
            dup_in = 1'b0;
            status_in = ocwt_pkg::StatusOk;
            fstate_in = ocwt_pkg::FoundAbsent;
            mvalid_in = 1'b0;
            mtime_in = '0;
         end
         ocwt_pkg::StScanCheck: begin
            if (!pos_set_ff && ram_rdata.source == src_ff && time_ff < ram_rdata.stamp) begin
               pos_in = idx_ff;
               pos_set_in = 1'b1;
            end
            if (match_op) begin
               self_in = idx_ff;
               self_set_in = 1'b1;
               dup_in = 1'b1;
               fstate_in = ram_rdata.committed ? ocwt_pkg::FoundCommitted
                                               : ocwt_pkg::FoundPending;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ocwt_pkg::StDecide: begin
            case (mode_ff)
               ocwt_pkg::ModeQueue: begin
                  if (dup_ff) status_in = ocwt_pkg::StatusDup;
                  else if (count_ff == CW'(ocwt_pkg::Capacity))
                     status_in = ocwt_pkg::StatusFull;
                  idx_in = count_ff;
               end
               ocwt_pkg::ModeCommit: begin
                  if (!self_set_ff) status_in = ocwt_pkg::StatusNotFound;
                  idx_in = '0;
               end
               default: begin
                  if (!self_set_ff) begin
                     status_in = ocwt_pkg::StatusNotFound;
                     fstate_in = ocwt_pkg::FoundAbsent;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
                  idx_in = self_ff;
               end
            endcase
         end
         ocwt_pkg::StMarkWrite: begin
            // The read data still holds the matched entry from the scan.
            ram_addr = self_ff[IW-1:0];
            ram_we = 1'b1;
            ram_wdata.committed = 1'b1;
         end
         ocwt_pkg::StWalkCheck: begin
            if (ram_rdata.source == src_ff) begin
               if (ram_rdata.committed || (self_set_ff && idx_ff == self_ff)) begin
                  mvalid_in = 1'b1;
                  mtime_in = ram_rdata.stamp;
               end
            end
            idx_in = idx_ff + 1'b1;
         end
         ocwt_pkg::StMoveRead: begin
            // Queue shifts up from the tail; graduate pulls down from above.
            if (mode_ff == ocwt_pkg::ModeQueue) ram_addr = IW'(idx_ff - 1'b1);
            else ram_addr = IW'(idx_ff + 1'b1);
         end
         ocwt_pkg::StMoveWrite: begin
            ram_we = 1'b1;
            if (mode_ff == ocwt_pkg::ModeQueue) idx_in = idx_ff - 1'b1;
            else idx_in = idx_ff + 1'b1;
         end
         ocwt_pkg::StInsert: begin
            ram_addr = pos_ff[IW-1:0];
            ram_we = 1'b1;
            ram_wdata.committed = 1'b0;
            ram_wdata.source = src_ff;
            ram_wdata.conn = conn_ff;
            ram_wdata.op = op_ff;
            ram_wdata.stamp = time_ff;
            count_in = count_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Outputs.
   always_comb begin
      busy = (state_ff != ocwt_pkg::StIdle);
      rsp_valid = (state_ff == ocwt_pkg::StRespond);
      rsp_status = status_ff;
      rsp_found_state = (mode_ff == ocwt_pkg::ModeGraduate) ? fstate_ff
                                                             : ocwt_pkg::FoundAbsent;
      rsp_max_valid = mvalid_ff;
      rsp_max_time = mtime_ff;
      if (mode_ff == ocwt_pkg::ModeCommit)
         rsp_source_out = has_ff ? $signed({1'b0, src_ff}) : -13'sd1;
      else rsp_source_out = '0;
   end
endmodule
`default_nettype wire
